// ===== hw/rtl/cbtm_pkg.sv =====
`default_nettype none
package cbtm_pkg;
    localparam int KEY_W_DEF   = 32;
    localparam int VALUE_W_DEF = 32;
    localparam int NODES_DEF   = 1024;

    localparam int IN_KEY_W  = 32;
    localparam int IN_VAL_W  = 32;
    localparam int STATUS_W  = 3;

    typedef enum logic [STATUS_W-1:0] {
        ST_HIT  = 3'd0,
        ST_MISS = 3'd1,
        ST_NEW  = 3'd2,
        ST_OVER = 3'd3,
        ST_FULL = 3'd4
    } status_t;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    typedef struct packed {
        logic                operation;
        logic [IN_KEY_W-1:0] key;
        logic [IN_VAL_W-1:0] value;
    } req_t;

    typedef struct packed {
        status_t             status;
        logic [IN_VAL_W-1:0] value_out;
    } rsp_t;
endpackage
`default_nettype wire

// ===== hw/rtl/cbtm_req_if.sv =====
`default_nettype none
interface cbtm_req_if import cbtm_pkg::*; ;
    logic valid;
    logic ready;
    req_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/cbtm_rsp_if.sv =====
`default_nettype none
interface cbtm_rsp_if import cbtm_pkg::*; ;
    logic valid;
    logic ready;
    rsp_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/crit_bit_tree_map_core.sv =====
`default_nettype none
// Key-value map held as a crit-bit tree in one node memory (registered read).
// Each request is a lookup or an insert and returns exactly one response.
// A lookup reads one node per tree level walked; an insert walks twice
// (find the closest leaf, then find the split point), scans the key
// difference one bit per cycle, and spends three writes on the split.
// The node memory read port sets the pace: one node read per level. The
// response register lets the next request enter while a response is still
// waiting. Node contents are undefined after reset; only written nodes are
// ever reached.
module crit_bit_tree_map_core
    import cbtm_pkg::*;
#(
    parameter int KEY_BITS   = KEY_W_DEF,
    parameter int VALUE_BITS = VALUE_W_DEF,
    parameter int NODE_COUNT = NODES_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    cbtm_req_if.sink    req,
    cbtm_rsp_if.source  rsp
);
    localparam int AW = $clog2(NODE_COUNT);
    localparam int CW = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
    localparam int FW = $clog2(NODE_COUNT + 1);

    typedef struct packed {
        logic                  internal;
        logic [CW-1:0]         crit;
        logic [AW-1:0]         left;
        logic [AW-1:0]         right;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } node_t;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RD1   = 4'd1;
    localparam logic [3:0] S_CHK1  = 4'd2;
    localparam logic [3:0] S_SCAN  = 4'd3;
    localparam logic [3:0] S_RD2   = 4'd4;
    localparam logic [3:0] S_CHK2  = 4'd5;
    localparam logic [3:0] S_WR1   = 4'd6;
    localparam logic [3:0] S_WR2   = 4'd7;
    localparam logic [3:0] S_WR3   = 4'd8;
    localparam logic [3:0] S_RESP  = 4'd9;

    // Node memory.
    node_t         mem [NODE_COUNT];
    node_t         rd_q;
    logic [AW-1:0] rd_addr;
    logic          we;
    logic [AW-1:0] wr_addr;
    node_t         wr_data;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_q <= mem[rd_addr];
    end

    logic [3:0]            state_reg, state_next;
    logic                  nonempty_reg, nonempty_next;
    logic [FW-1:0]         free_reg, free_next;
    logic                  op_reg, op_next;
    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic [AW-1:0]         node_reg, node_next;
    logic [CW-1:0]         cb_reg, cb_next;
    logic [KEY_BITS-1:0]   diff_reg, diff_next;
    node_t                 split_reg, split_next;
    logic [FW-1:0]         steps_reg, steps_next;
    logic                  ovalid_reg, ovalid_next;
    rsp_t                  opay_reg, opay_next;
    status_t               st_reg, st_next;
    logic [IN_VAL_W-1:0]   vout_reg, vout_next;

    logic                  rd_bit;
    logic [AW-1:0]         child;
    logic                  child_ok;
    logic                  bit_ins;

    assign req.ready   = (state_reg == S_IDLE);
    assign rsp.valid   = ovalid_reg;
    assign rsp.payload = opay_reg;

    // Child selection from the node just read.
    always_comb
    begin
        rd_bit   = key_reg[rd_q.crit];
        child    = rd_bit ? rd_q.right : rd_q.left;
        child_ok = (child != node_reg);
        bit_ins  = key_reg[cb_reg];
    end

    // Control sequence.
    always_comb
    begin
        state_next    = state_reg;
        nonempty_next = nonempty_reg;
        free_next     = free_reg;
        op_next       = op_reg;
        key_next      = key_reg;
        val_next      = val_reg;
        node_next     = node_reg;
        cb_next       = cb_reg;
        diff_next     = diff_reg;
        split_next    = split_reg;
        steps_next    = steps_reg;
        st_next       = st_reg;
        vout_next     = vout_reg;
        ovalid_next   = ovalid_reg;
        opay_next     = opay_reg;
        rd_addr       = node_reg;
        we            = 1'b0;
        wr_addr       = node_reg;
        wr_data       = rd_q;

        if (ovalid_reg && rsp.ready)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid && req.ready)
                begin
                    op_next    = req.payload.operation;
                    key_next   = req.payload.key[KEY_BITS-1:0];
                    val_next   = req.payload.value[VALUE_BITS-1:0];
                    node_next  = '0;
                    steps_next = '0;
                    vout_next  = '0;
                    rd_addr    = '0;
                    if (!nonempty_reg)
                    begin
                        if (req.payload.operation == OP_LOOKUP)
                        begin
                            st_next    = ST_MISS;
                            state_next = S_RESP;
                        end
                        else if (NODE_COUNT < 1)
                        begin
                            st_next    = ST_FULL;
                            state_next = S_RESP;
                        end
                        else
                        begin
                            we      = 1'b1;
                            wr_addr = '0;
                            wr_data = '{internal: 1'b0, crit: '0, left: '0, right: '0,
                                        key: req.payload.key[KEY_BITS-1:0],
                                        value: req.payload.value[VALUE_BITS-1:0]};
                            free_next     = FW'(1);
                            nonempty_next = 1'b1;
                            st_next       = ST_NEW;
                            state_next    = S_RESP;
                        end
                    end
                    else
                    begin
                        state_next = S_RD1;
                    end
                end
            end
            // Read of node_reg is in flight.
            S_RD1:
            begin
                state_next = S_CHK1;
            end
            S_CHK1:
            begin
                if (rd_q.internal && steps_reg < FW'(NODE_COUNT) && child_ok)
                begin
                    node_next  = child;
                    rd_addr    = child;
                    steps_next = steps_reg + 1'b1;
                    state_next = S_RD1;
                end
                else if (rd_q.key == key_reg)
                begin
                    if (op_reg == OP_LOOKUP)
                    begin
                        st_next   = ST_HIT;
                        vout_next = IN_VAL_W'(rd_q.value);
                    end
                    else
                    begin
                        we            = 1'b1;
                        wr_data       = rd_q;
                        wr_data.value = val_reg;
                        st_next       = ST_OVER;
                    end
                    state_next = S_RESP;
                end
                else if (op_reg == OP_LOOKUP)
                begin
                    st_next    = ST_MISS;
                    state_next = S_RESP;
                end
                else if (free_reg + FW'(2) > FW'(NODE_COUNT) || free_reg > FW'(NODE_COUNT - 2))
                begin
                    st_next    = ST_FULL;
                    state_next = S_RESP;
                end
                else
                begin
                    diff_next  = rd_q.key ^ key_reg;
                    cb_next    = '0;
                    state_next = S_SCAN;
                end
            end
            // Lowest differing bit, one bit per cycle.
            S_SCAN:
            begin
                if (diff_reg[0])
                begin
                    node_next  = '0;
                    rd_addr    = '0;
                    steps_next = '0;
                    state_next = S_RD2;
                end
                else
                begin
                    diff_next = diff_reg >> 1;
                    cb_next   = cb_reg + 1'b1;
                end
            end
            S_RD2:
            begin
                state_next = S_CHK2;
            end
            S_CHK2:
            begin
                if (rd_q.internal && cb_reg > rd_q.crit
                    && steps_reg < FW'(NODE_COUNT) && child_ok)
                begin
                    node_next  = child;
                    rd_addr    = child;
                    steps_next = steps_reg + 1'b1;
                    state_next = S_RD2;
                end
                else
                begin
                    split_next = rd_q;
                    state_next = S_WR1;
                end
            end
            // New leaf at the first free node.
            S_WR1:
            begin
                we         = 1'b1;
                wr_addr    = free_reg[AW-1:0];
                wr_data    = '{internal: 1'b0, crit: '0, left: '0, right: '0,
                               key: key_reg, value: val_reg};
                state_next = S_WR2;
            end
            // Copy of the old node at the next one.
            S_WR2:
            begin
                we         = 1'b1;
                wr_addr    = AW'(free_reg + FW'(1));
                wr_data    = split_reg;
                state_next = S_WR3;
            end
            // The split node becomes internal.
            S_WR3:
            begin
                we               = 1'b1;
                wr_addr          = node_reg;
                wr_data          = split_reg;
                wr_data.internal = 1'b1;
                wr_data.crit     = cb_reg;
                wr_data.left     = bit_ins ? AW'(free_reg + FW'(1)) : free_reg[AW-1:0];
                wr_data.right    = bit_ins ? free_reg[AW-1:0] : AW'(free_reg + FW'(1));
                free_next        = free_reg + FW'(2);
                st_next          = ST_NEW;
                state_next       = S_RESP;
            end
            S_RESP:
            begin
                if (!ovalid_reg || rsp.ready)
                begin
                    ovalid_next = 1'b1;
                    opay_next   = '{status: st_reg, value_out: vout_reg};
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            nonempty_reg <= 1'b0;
            free_reg     <= '0;
            ovalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            nonempty_reg <= nonempty_next;
            free_reg     <= free_next;
            ovalid_reg   <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        key_reg   <= key_next;
        val_reg   <= val_next;
        node_reg  <= node_next;
        cb_reg    <= cb_next;
        diff_reg  <= diff_next;
        split_reg <= split_next;
        steps_reg <= steps_next;
        st_reg    <= st_next;
        vout_reg  <= vout_next;
        opay_reg  <= opay_next;
    end
endmodule
`default_nettype wire
